### hdl/finite_difference_velocity_macros.svh
// Assertion macros shared by the checker.
`ifndef FINITE_DIFFERENCE_VELOCITY_MACROS_SVH
`define FINITE_DIFFERENCE_VELOCITY_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FDV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked on every clock edge outside reset.
`define FDV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hdl/fdv_pkg.sv
`default_nettype none
package fdv_pkg;
   localparam int PosW = 32;
   localparam int DirFrac = 14;
   localparam int Lanes = 3;
   localparam int CsrIdxW = 1;
   localparam int CsrDataW = 16;
   localparam logic [CsrIdxW-1:0] CSR_MIN_TIME_STEP = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_MIN_SPEED = 1'b1;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0] time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0] speed;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
      logic saturated;
   } rsp_type;

   // lane control from sequencer
   typedef struct packed {
      logic start;
      logic [63:0] divisor;
   } lane_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } lane_sts_type;
endpackage
`default_nettype wire

### hdl/fdv_div_lane.sv
`default_nettype none
// Restoring divider lane: 64-bit dividend over 64-bit divisor, one bit a cycle.
module fdv_div_lane (
   input  wire logic clock,
   input  wire logic reset,
   input  wire fdv_pkg::lane_ctl_type ctl,
   input  wire logic [63:0] dividend,
   output fdv_pkg::lane_sts_type sts,
   output logic [63:0] quotient
);
   import fdv_pkg::*;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[63:0], quo_ff[63]} - {1'b0, dvs_ff};
      if (ctl.start) begin
         rem_in = '0;
         quo_in = dividend;
         dvs_in = ctl.divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[63:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

### hdl/fdv_sqrt.sv
`default_nettype none
// Bit-pair integer square root of a 66-bit value, one result bit a cycle.
module fdv_sqrt (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [65:0] radicand,
   output fdv_pkg::lane_sts_type sts,
   output logic [32:0] root
);
   import fdv_pkg::*;
   logic [65:0] rad_ff, rad_in;
   logic [35:0] rem_ff, rem_in;
   logic [32:0] root_ff, root_in;
   logic [5:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [35:0] shifted, trial;

   always_comb begin
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[33:0], rad_ff[65:64]};
      trial = shifted - {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in = radicand;
         rem_in = '0;
         root_in = '0;
         cnt_in = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[63:0], 2'b00};
         if (!trial[35]) begin
            rem_in = trial;
            root_in = {root_ff[31:0], 1'b1};
         end else begin
            rem_in = shifted;
            root_in = {root_ff[31:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign root = root_ff;
endmodule
`default_nettype wire

### hdl/finite_difference_velocity.sv
`default_nettype none
// Three-axis finite-difference velocity estimator. One item at a time. When the
// step is usable, an item passes these parts in order: start the three divider
// lanes, the 64-bit velocity division, the speed square root (sum, start, 33
// root bits, done), pick the direction vector, the norm square root, start the
// lanes again and the direction division. A zero step, or one below min_time_step,
// skips the first three parts; a zero direction vector skips the last two. The
// result is held in rsp_ until taken; req_stall is high from acceptance until the
// cycle after the result leaves. Configuration via csr_ is meant for idle periods
// only.
module finite_difference_velocity (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire fdv_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output fdv_pkg::rsp_type rsp_data,
   input  wire logic csr_write,
   input  wire logic [fdv_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [fdv_pkg::CsrDataW-1:0] csr_data
);
   import fdv_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_VDIV  = 9'b000000010,
      S_VWAIT = 9'b000000100,
      S_SPEED = 9'b000001000,
      S_NPREP = 9'b000010000,
      S_NORM  = 9'b000100000,
      S_DDIV  = 9'b001000000,
      S_DWAIT = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [15:0] min_ts_ff, min_sp_ff;
   logic signed [PosW-1:0] prev_ff [Lanes];
   logic signed [PosW-1:0] cur_ff [Lanes];
   logic [31:0] dt_ff;
   logic signed [31:0] vel_ff [Lanes];
   logic [31:0] m_ff [Lanes];
   logic [31:0] speed_ff;
   logic sat_ff, usepos_ff;
   logic [32:0] norm_ff;
   logic sq_phase_ff;
   logic [65:0] sqsum_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   lane_ctl_type lane_ctl;
   lane_sts_type lane_sts [Lanes];
   logic [63:0] lane_dvd [Lanes];
   logic [63:0] lane_q [Lanes];
   logic lanes_done;
   logic sq_start;
   logic sq_load;
   logic [65:0] sq_rad;
   lane_sts_type sq_sts;
   logic [32:0] sq_root;

   logic accept;
   logic small_dt;
   logic vel_done, dir_done, zero_norm;

   logic signed [PosW:0] diff [Lanes];
   logic [PosW:0] dmag [Lanes];
   logic [31:0] vlim [Lanes];
   logic [31:0] vmag [Lanes];
   logic [Lanes-1:0] vclip;
   logic [32:0] cmag [Lanes];
   logic [14:0] dq [Lanes];
   logic [15:0] dsgn [Lanes];
   logic [63:0] sq [Lanes];

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign small_dt = (req_data.time_step == 32'd0) || (req_data.time_step < 32'(min_ts_ff));

   // With 32-bit positions every magnitude is at most 2^31, so the vector never
   // needs scaling down before its squares are summed.
   always_comb begin
      lanes_done = 1'b1;
      for (int i = 0; i < Lanes; i++) begin
         lanes_done = lanes_done & lane_sts[i].done;
         diff[i] = {cur_ff[i][PosW-1], cur_ff[i]} - {prev_ff[i][PosW-1], prev_ff[i]};
         dmag[i] = diff[i][PosW] ? (PosW+1)'(-diff[i]) : (PosW+1)'(diff[i]);
         vlim[i] = diff[i][PosW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         vclip[i] = lane_q[i] > 64'(vlim[i]);
         vmag[i] = vclip[i] ? vlim[i] : lane_q[i][31:0];
         cmag[i] = usepos_ff
            ? (cur_ff[i][PosW-1] ? 33'(-{cur_ff[i][PosW-1], cur_ff[i]})
                                 : 33'({1'b0, cur_ff[i]}))
            : (vel_ff[i][31] ? 33'(-{vel_ff[i][31], vel_ff[i]}) : {1'b0, vel_ff[i]});
         dq[i] = (lane_q[i] > 64'd32767) ? 15'h7FFF : lane_q[i][14:0];
         dsgn[i] = (usepos_ff ? cur_ff[i][PosW-1] : vel_ff[i][31])
            ? 16'(-{1'b0, dq[i]}) : {1'b0, dq[i]};
         sq[i] = 64'(m_ff[i]) * 64'(m_ff[i]);
      end
   end

   always_comb begin
      lane_ctl.start = (state_ff == S_VDIV) || (state_ff == S_DDIV);
      lane_ctl.divisor = (state_ff == S_VDIV) ? 64'(dt_ff) : 64'(norm_ff);
      for (int i = 0; i < Lanes; i++)
         lane_dvd[i] = (state_ff == S_VDIV) ? (64'(dmag[i]) << 16)
                                             : (64'(m_ff[i]) << DirFrac);
   end

   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      fdv_div_lane u_div (
         .clock(clock), .reset(reset), .ctl(lane_ctl), .dividend(lane_dvd[g]),
         .sts(lane_sts[g]), .quotient(lane_q[g]));
   end

   fdv_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .radicand(sq_rad),
      .sts(sq_sts), .root(sq_root));

   // square root runs: the sum is registered, and the start pulse follows in the next cycle
   assign sq_load = ((state_ff == S_SPEED) || (state_ff == S_NORM))
                    && !sq_sts.busy && !sq_sts.done && !sq_phase_ff;
   assign sq_start = sq_phase_ff;
   assign sq_rad = sqsum_ff;

   assign vel_done = (state_ff == S_VWAIT) && lanes_done;
   assign dir_done = (state_ff == S_DWAIT) && lanes_done;
   assign zero_norm = (state_ff == S_NORM) && sq_sts.done && (sq_root == 33'd0);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = small_dt ? S_NPREP : S_VDIV;
         S_VDIV: state_in = S_VWAIT;
         S_VWAIT: if (lanes_done) state_in = S_SPEED;
         S_SPEED: if (sq_sts.done) state_in = S_NPREP;
         S_NPREP: state_in = S_NORM;
         S_NORM: if (sq_sts.done) state_in = (sq_root == 33'd0) ? S_OUT : S_DDIV;
         S_DDIV: state_in = S_DWAIT;
         S_DWAIT: if (lanes_done) state_in = S_OUT;
         S_OUT: if (!rsp_valid_ff) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         min_ts_ff <= 16'd1;
         min_sp_ff <= 16'd0;
         rsp_valid_ff <= 1'b0;
         sq_phase_ff <= 1'b0;
         for (int i = 0; i < Lanes; i++) prev_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         sq_phase_ff <= sq_load;
         if (csr_write) begin
            unique case (csr_index)
               CSR_MIN_TIME_STEP: min_ts_ff <= csr_data;
               CSR_MIN_SPEED: min_sp_ff <= csr_data;
               default: ;
            endcase
         end
         if (dir_done || zero_norm) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == S_OUT && !rsp_valid_ff) begin
            for (int i = 0; i < Lanes; i++) prev_ff[i] <= cur_ff[i];
         end
      end
      if (accept) begin
         cur_ff[0] <= req_data.pos_x;
         cur_ff[1] <= req_data.pos_y;
         cur_ff[2] <= req_data.pos_z;
         dt_ff <= req_data.time_step;
         sat_ff <= 1'b0;
         speed_ff <= '0;
         usepos_ff <= 1'b1;
         for (int i = 0; i < Lanes; i++) vel_ff[i] <= '0;
      end
      if (vel_done) begin
         for (int i = 0; i < Lanes; i++) begin
            vel_ff[i] <= diff[i][PosW] ? 32'(-vmag[i]) : vmag[i];
            m_ff[i] <= vmag[i];
         end
         sat_ff <= |vclip;
      end
      if (state_ff == S_NPREP) begin
         for (int i = 0; i < Lanes; i++) m_ff[i] <= cmag[i][31:0];
      end
      if (sq_load) sqsum_ff <= 66'(sq[0]) + 66'(sq[1]) + 66'(sq[2]);
      if (state_ff == S_SPEED && sq_sts.done) begin
         speed_ff <= sq_root[31:0];
         usepos_ff <= !(sq_root > 33'(min_sp_ff));
      end
      if (state_ff == S_NORM && sq_sts.done) norm_ff <= sq_root;
      if (dir_done || zero_norm) begin
         rsp_ff.vel_x <= vel_ff[0];
         rsp_ff.vel_y <= vel_ff[1];
         rsp_ff.vel_z <= vel_ff[2];
         rsp_ff.speed <= speed_ff;
         rsp_ff.saturated <= sat_ff;
         rsp_ff.dir_x <= dir_done ? dsgn[0] : 16'd0;
         rsp_ff.dir_y <= dir_done ? dsgn[1] : 16'd0;
         rsp_ff.dir_z <= dir_done ? dsgn[2] : 16'd0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

### hdl/fdv_checker.sv
`default_nettype none
`include "finite_difference_velocity_macros.svh"
module fdv_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);
   import fdv_pkg::*;
   `FDV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `FDV_ASSERT_IMPL(a_busy_when_rsp, clock, reset, rsp_valid, req_stall)
   `FDV_ASSERT_NEXT(a_accept_stalls, clock, reset, req_valid && !req_stall, req_stall)
endmodule

bind finite_difference_velocity fdv_checker u_fdv_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall));
`default_nettype wire

### verif/tb.sv
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fdv_pkg::*;

   typedef enum int {IDLE_SEND_SLOW, IDLE_RECV_SLOW, IDLE_NONE} idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [CsrIdxW-1:0] csr_index = CSR_MIN_TIME_STEP;
   logic [CsrDataW-1:0] csr_data = '0;

   finite_difference_velocity u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   req_type pending_samples[$];
   rsp_type expected_vel[$];
   int fail_count = 0;
   int send_idle_pct = 29;
   int recv_idle_pct = 84;
   bit hold_go = 0;
   bit hold_done = 0;
   int hold_left = 0;

   // predictor state
   logic [15:0] mdl_min_step = 16'd1;
   logic [15:0] mdl_min_speed = 16'd0;
   longint prev_pos[3] = '{0, 0, 0};

   // generator's running position
   int gen_pos[3] = '{0, 0, 0};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] n);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n = n - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   // returns {clipped, velocity}
   function automatic logic [32:0] div_velocity(input longint d, input logic [63:0] dt);
      logic [63:0] a, q1, r1, limit, q;
      logic clipped;
      clipped = 0;
      a = (d < 0) ? -d : d;
      q1 = a / dt;
      r1 = a % dt;
      limit = (d < 0) ? (64'd1 << 31) : ((64'd1 << 31) - 1);
      if (q1 >= 64'd65536) q = limit + 1;
      else q = (q1 << 16) + ((r1 << 16) / dt);
      if (q > limit) begin
         q = limit;
         clipped = 1;
      end
      if (d < 0) q = -q;
      return {clipped, q[31:0]};
   endfunction

   function automatic logic [47:0] unit_dir(input longint c0, input longint c1,
                                            input longint c2);
      longint c[3];
      logic [63:0] m[3];
      logic [63:0] mx, norm, q;
      logic [15:0] d[3];
      c = '{c0, c1, c2};
      for (int i = 0; i < 3; i++) m[i] = (c[i] < 0) ? -c[i] : c[i];
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      while (mx > (64'd1 << 31)) begin
         mx = mx >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      norm = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (norm != 0) q = (m[i] << DirFrac) / norm;
         if (q > 64'd32767) q = 64'd32767;
         if (c[i] < 0) q = -q;
         d[i] = q[15:0];
      end
      return {d[0], d[1], d[2]};
   endfunction

   task automatic predict_velocity(input req_type s);
      longint cur[3], vel[3];
      logic [63:0] dt, s2, spd, mg;
      logic [32:0] dv;
      logic [47:0] dir;
      bit clipped, use_pos;
      rsp_type r;
      cur[0] = longint'(s.pos_x);
      cur[1] = longint'(s.pos_y);
      cur[2] = longint'(s.pos_z);
      vel = '{0, 0, 0};
      dt = {32'd0, s.time_step};
      clipped = 0;
      use_pos = 1;
      spd = 0;
      if (dt != 0 && dt >= {48'd0, mdl_min_step}) begin
         s2 = 0;
         for (int i = 0; i < 3; i++) begin
            dv = div_velocity(cur[i] - prev_pos[i], dt);
            clipped |= dv[32];
            vel[i] = longint'($signed(dv[31:0]));
            mg = (vel[i] < 0) ? -vel[i] : vel[i];
            s2 += mg * mg;
         end
         spd = int_sqrt(s2);
         use_pos = !(spd > {48'd0, mdl_min_speed});
      end
      dir = use_pos ? unit_dir(cur[0], cur[1], cur[2]) : unit_dir(vel[0], vel[1], vel[2]);
      r.vel_x = vel[0][31:0];
      r.vel_y = vel[1][31:0];
      r.vel_z = vel[2][31:0];
      r.speed = spd[31:0];
      r.dir_x = dir[47:32];
      r.dir_y = dir[31:16];
      r.dir_z = dir[15:0];
      r.saturated = clipped;
      expected_vel.push_back(r);
      prev_pos = cur;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_velocity(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_samples.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_go && !hold_done) begin
         hold_left <= 3000;
         hold_done <= 1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor and receiver
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b1;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_vel.size() == 0) begin
               $error("unexpected result transfer");
               fail_count++;
            end else begin
               e = expected_vel.pop_front();
               if (rsp_data.vel_x !== e.vel_x) begin
                  $error("vel_x exp %0d got %0d", e.vel_x, rsp_data.vel_x); fail_count++;
               end
               if (rsp_data.vel_y !== e.vel_y) begin
                  $error("vel_y exp %0d got %0d", e.vel_y, rsp_data.vel_y); fail_count++;
               end
               if (rsp_data.vel_z !== e.vel_z) begin
                  $error("vel_z exp %0d got %0d", e.vel_z, rsp_data.vel_z); fail_count++;
               end
               if (rsp_data.speed !== e.speed) begin
                  $error("speed exp %0d got %0d", e.speed, rsp_data.speed); fail_count++;
               end
               if (rsp_data.dir_x !== e.dir_x) begin
                  $error("dir_x exp %0d got %0d", e.dir_x, rsp_data.dir_x); fail_count++;
               end
               if (rsp_data.dir_y !== e.dir_y) begin
                  $error("dir_y exp %0d got %0d", e.dir_y, rsp_data.dir_y); fail_count++;
               end
               if (rsp_data.dir_z !== e.dir_z) begin
                  $error("dir_z exp %0d got %0d", e.dir_z, rsp_data.dir_z); fail_count++;
               end
               if (rsp_data.saturated !== e.saturated) begin
                  $error("saturated exp %0d got %0d", e.saturated, rsp_data.saturated);
                  fail_count++;
               end
            end
         end
         if ((hold_go && !hold_done) || hold_left > 0) begin
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   task automatic add_sample(input int x, input int y, input int z, input logic [31:0] dt);
      req_type s;
      s.pos_x = x;
      s.pos_y = y;
      s.pos_z = z;
      s.time_step = dt;
      pending_samples.push_back(s);
   endtask

   // checked between edges so that the driver's updates have settled
   task automatic wait_drained();
      @(negedge clock);
      while (pending_samples.size() > 0 || expected_vel.size() > 0 || req_valid)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CsrIdxW-1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_MIN_TIME_STEP) mdl_min_step = val;
      else if (idx == CSR_MIN_SPEED) mdl_min_speed = val;
   endtask

   task automatic set_idle(input idle_mode_type m);
      case (m)
         IDLE_SEND_SLOW: begin send_idle_pct = 29; recv_idle_pct = 84; end
         IDLE_RECV_SLOW: begin send_idle_pct = 84; recv_idle_pct = 29; end
         default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
   endtask

   task automatic add_random(input int count);
      logic [31:0] dt;
      for (int n = 0; n < count; n++) begin
         for (int a = 0; a < 3; a++) begin
            case ($urandom_range(0, 9))
               0: gen_pos[a] = $urandom;
               1: case ($urandom_range(0, 2))
                     0: gen_pos[a] = 32'h8000_0000;
                     1: gen_pos[a] = 32'h7fff_ffff;
                     default: gen_pos[a] = 0;
                  endcase
               2: gen_pos[a] = gen_pos[a];
               default: gen_pos[a] = gen_pos[a] + ($urandom_range(0, 1 << 18) - (1 << 17));
            endcase
         end
         case ($urandom_range(0, 9))
            0: dt = 0;
            1: dt = $urandom;
            2: dt = $urandom_range(0, 70000);
            3: dt = {16'd0, mdl_min_step} + $urandom_range(0, 2) - 1;
            default: dt = $urandom_range(256, 1 << 17);
         endcase
         add_sample(gen_pos[0], gen_pos[1], gen_pos[2], dt);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, no step, repeat position, saturation
      set_idle(IDLE_SEND_SLOW);
      add_sample(0, 0, 0, 0);
      add_sample(0, 0, 0, 32'h0001_0000);
      add_sample(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
      add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
      add_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000);
      add_sample(32'h7fff_ffff, 0, 32'h8000_0000, 32'hffff_ffff);
      add_sample(32'h0001_0000, -32'sh0002_0000, 32'h0003_0000, 0);
      add_sample(32'h0002_0000, -32'sh0001_0000, 32'h0003_0000, 32'h0000_8000);
      add_sample(32'h0002_0000, -32'sh0001_0000, 32'h0003_0000, 32'h0000_8000);
      add_sample(-1, 1, 0, 32'd1);
      add_sample(0, 0, 32'h7fff_ffff, 32'h0000_0002);
      add_sample(12345, -67890, 424242, 32'hffff_ffff);
      add_sample(32'h8000_0000, 32'h7fff_ffff, 0, 32'h8000_0000);
      add_sample(0, 0, 0, 32'd1);
      wait_drained();

      add_random(450);
      wait_drained();

      set_idle(IDLE_RECV_SLOW);
      write_csr(CSR_MIN_TIME_STEP, 16'd0);
      write_csr(CSR_MIN_SPEED, 16'd0);
      add_random(450);
      wait_drained();

      write_csr(CSR_MIN_TIME_STEP, 16'hffff);
      write_csr(CSR_MIN_SPEED, 16'hffff);
      add_random(400);
      wait_drained();

      set_idle(IDLE_NONE);
      hold_go = 1;
      write_csr(CSR_MIN_TIME_STEP, 16'($urandom_range(0, 65535)));
      write_csr(CSR_MIN_SPEED, 16'($urandom_range(0, 65535)));
      add_random(350);
      wait_drained();

      write_csr(CSR_MIN_TIME_STEP, 16'd1);
      write_csr(CSR_MIN_SPEED, 16'd0);
      add_random(350);
      wait_drained();

      repeat (300) @(posedge clock);
      if (fail_count == 0 && expected_vel.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
